FILE: hdl/jspt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jspt_pkg;

  // Width of the pair counter unless the top level is told otherwise.
  localparam int PAIR_COUNT_WIDTH_DEFAULT = 8;

  // Characters that the grammar looks for.
  localparam logic [7:0] CH_OPEN_BRACE  = 8'h7B;
  localparam logic [7:0] CH_CLOSE_BRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE       = 8'h22;
  localparam logic [7:0] CH_COLON       = 8'h3A;
  localparam logic [7:0] CH_COMMA       = 8'h2C;
  localparam logic [7:0] CH_NUL         = 8'h00;
  localparam logic [7:0] CH_TAB         = 8'h09;
  localparam logic [7:0] CH_CR          = 8'h0D;
  localparam logic [7:0] CH_SPACE       = 8'h20;

  // Parser phase.
  typedef enum logic [3:0] {
    PH_OPEN        = 4'd0,
    PH_KEY_QUOTE   = 4'd1,
    PH_KEY_BODY    = 4'd2,
    PH_COLON       = 4'd3,
    PH_VALUE_QUOTE = 4'd4,
    PH_VALUE_BODY  = 4'd5,
    PH_AFTER_VALUE = 4'd6,
    PH_FINISHED    = 4'd7,
    PH_FAILED      = 4'd8
  } phase_t;

  // Kind of a result word.
  typedef enum logic [2:0] {
    KIND_KEY_BYTE   = 3'd0,
    KIND_VALUE_BYTE = 3'd1,
    KIND_KEY_END    = 3'd2,
    KIND_VALUE_END  = 3'd3,
    KIND_OBJ_END    = 3'd4,
    KIND_EMPTY_END  = 3'd5,
    KIND_ERROR      = 3'd6
  } kind_t;

  // Error codes carried with an error word.
  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_NO_BRACE    = 3'd1,
    ERR_NO_KEY_QUOTE = 3'd2,
    ERR_NO_COLON    = 3'd3,
    ERR_NO_VAL_QUOTE = 3'd4,
    ERR_UNTERMINATED = 3'd5,
    ERR_TRAILING    = 3'd6
  } err_t;

  // One input word.
  typedef struct packed {
    logic       first;
    logic [7:0] text_byte;
  } item_t;

  // One result word.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] pair_number;
    err_t       error_code;
  } result_t;

  // Whitespace skipped between tokens: tab through carriage return, and space.
  function automatic logic is_blank(input logic [7:0] c);
    logic res;
    res = ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/json_string_pair_tokenizer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Signals                           | Word
// ---------+-----------------------------------+----------------------------------
// input    | item_valid, item_ready, item      | first flag and one text byte
// output   | result_valid, result_ready, result| kind, data byte, pair, error code
//
// One text byte is taken every clock cycle unless a stalled result register holds the
// input register. An accepted byte is decoded from the input register into the result
// register, where its result word, if it makes one, is registered.
// Reset (rst, synchronous) empties both registers and returns the parser to
// waiting for the opening brace with a pair count of zero.
// A stalled result register holds the input register only when the byte in it
// makes a result; bytes that make none still pass through.
module json_string_pair_tokenizer_top #(
  parameter int PAIR_COUNT_WIDTH = jspt_pkg::PAIR_COUNT_WIDTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire jspt_pkg::item_t  item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output jspt_pkg::result_t     result
);

  localparam logic [PAIR_COUNT_WIDTH-1:0] COUNT_MAX = {PAIR_COUNT_WIDTH{1'b1}};

  // Input register.
  logic            s1_valid;
  jspt_pkg::item_t s1;

  // Parser state.
  jspt_pkg::phase_t            phase;
  jspt_pkg::phase_t            phase_next;
  logic [PAIR_COUNT_WIDTH-1:0] pair_count;
  logic [PAIR_COUNT_WIDTH-1:0] pair_count_next;

  // Decode signals.
  jspt_pkg::phase_t            phase_cur;
  logic [PAIR_COUNT_WIDTH-1:0] count_cur;
  logic [7:0]                  shown;
  logic                        emit;
  jspt_pkg::result_t           res;
  logic                        proc;
  logic [7:0]                  c;

  // The first flag restarts the parser before the byte is decoded.
  assign phase_cur = s1.first ? jspt_pkg::PH_OPEN : phase;
  assign count_cur = s1.first ? '0 : pair_count;
  assign c         = s1.text_byte;

  // Pair number as shown on the result, saturated to eight bits.
  generate
    if (PAIR_COUNT_WIDTH > 8) begin : g_wide
      assign shown = (count_cur > PAIR_COUNT_WIDTH'(255)) ? 8'hFF : count_cur[7:0];
    end else begin : g_narrow
      assign shown = 8'(count_cur);
    end
  endgenerate

  // Phase decode for the byte in the input register.
  always_comb begin
    phase_next      = phase_cur;
    pair_count_next = count_cur;
    emit            = 1'b0;
    res.kind        = jspt_pkg::KIND_ERROR;
    res.data_byte   = 8'h00;
    res.pair_number = shown;
    res.error_code  = jspt_pkg::ERR_NONE;
    unique case (phase_cur)
      jspt_pkg::PH_OPEN: begin
        if (!jspt_pkg::is_blank(c)) begin
          if (c == jspt_pkg::CH_CLOSE_BRACE || c == jspt_pkg::CH_NUL) begin
            phase_next = jspt_pkg::PH_FINISHED;
            emit       = 1'b1;
            res.kind   = jspt_pkg::KIND_EMPTY_END;
          end else if (c == jspt_pkg::CH_OPEN_BRACE) begin
            phase_next = jspt_pkg::PH_KEY_QUOTE;
          end else begin
            phase_next     = jspt_pkg::PH_FAILED;
            emit           = 1'b1;
            res.error_code = jspt_pkg::ERR_NO_BRACE;
          end
        end
      end
      jspt_pkg::PH_KEY_QUOTE: begin
        if (!jspt_pkg::is_blank(c)) begin
          if (c == jspt_pkg::CH_QUOTE) begin
            phase_next = jspt_pkg::PH_KEY_BODY;
          end else begin
            phase_next     = jspt_pkg::PH_FAILED;
            emit           = 1'b1;
            res.error_code = jspt_pkg::ERR_NO_KEY_QUOTE;
          end
        end
      end
      jspt_pkg::PH_KEY_BODY: begin
        emit = 1'b1;
        if (c == jspt_pkg::CH_QUOTE) begin
          phase_next = jspt_pkg::PH_COLON;
          res.kind   = jspt_pkg::KIND_KEY_END;
        end else if (c == jspt_pkg::CH_NUL) begin
          phase_next     = jspt_pkg::PH_FAILED;
          res.error_code = jspt_pkg::ERR_UNTERMINATED;
        end else begin
          res.kind      = jspt_pkg::KIND_KEY_BYTE;
          res.data_byte = c;
        end
      end
      jspt_pkg::PH_COLON: begin
        if (!jspt_pkg::is_blank(c)) begin
          if (c == jspt_pkg::CH_COLON) begin
            phase_next = jspt_pkg::PH_VALUE_QUOTE;
          end else begin
            phase_next     = jspt_pkg::PH_FAILED;
            emit           = 1'b1;
            res.error_code = jspt_pkg::ERR_NO_COLON;
          end
        end
      end
      jspt_pkg::PH_VALUE_QUOTE: begin
        if (!jspt_pkg::is_blank(c)) begin
          if (c == jspt_pkg::CH_QUOTE) begin
            phase_next = jspt_pkg::PH_VALUE_BODY;
          end else begin
            phase_next     = jspt_pkg::PH_FAILED;
            emit           = 1'b1;
            res.error_code = jspt_pkg::ERR_NO_VAL_QUOTE;
          end
        end
      end
      jspt_pkg::PH_VALUE_BODY: begin
        emit = 1'b1;
        if (c == jspt_pkg::CH_QUOTE) begin
          phase_next = jspt_pkg::PH_AFTER_VALUE;
          res.kind   = jspt_pkg::KIND_VALUE_END;
        end else if (c == jspt_pkg::CH_NUL) begin
          phase_next     = jspt_pkg::PH_FAILED;
          res.error_code = jspt_pkg::ERR_UNTERMINATED;
        end else begin
          res.kind      = jspt_pkg::KIND_VALUE_BYTE;
          res.data_byte = c;
        end
      end
      jspt_pkg::PH_AFTER_VALUE: begin
        if (!jspt_pkg::is_blank(c)) begin
          if (c == jspt_pkg::CH_COMMA) begin
            phase_next = jspt_pkg::PH_KEY_QUOTE;
            if (count_cur != COUNT_MAX) begin
              pair_count_next = count_cur + PAIR_COUNT_WIDTH'(1);
            end
          end else if (c == jspt_pkg::CH_CLOSE_BRACE || c == jspt_pkg::CH_NUL) begin
            phase_next = jspt_pkg::PH_FINISHED;
            emit       = 1'b1;
            res.kind   = jspt_pkg::KIND_OBJ_END;
          end else begin
            phase_next     = jspt_pkg::PH_FAILED;
            emit           = 1'b1;
            res.error_code = jspt_pkg::ERR_TRAILING;
          end
        end
      end
      default: begin
        // Finished or failed: bytes are dropped until the next first flag.
      end
    endcase
  end

  // The decode advances unless it has a word to give and the result register is full.
  assign proc       = s1_valid && (!emit || !result_valid || result_ready);
  assign item_ready = !s1_valid || proc;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      s1_valid <= 1'b1;
    end else if (proc) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1 <= item;
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= jspt_pkg::PH_OPEN;
      pair_count <= '0;
    end else if (proc) begin
      phase      <= phase_next;
      pair_count <= pair_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (proc && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      result <= res;
    end
  end

  // An error word always carries a code, and no other word does.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.kind == jspt_pkg::KIND_ERROR) ==
                      (result.error_code != jspt_pkg::ERR_NONE)))
    else $error("error code does not match result kind");

  // Only key and value bytes carry data.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind != jspt_pkg::KIND_KEY_BYTE &&
     result.kind != jspt_pkg::KIND_VALUE_BYTE) |-> (result.data_byte == 8'h00))
    else $error("data byte set on a non-data word");

  // Reporting an error leaves the parser failed.
  assert property (@(posedge clk) disable iff (rst)
    (proc && emit && res.kind == jspt_pkg::KIND_ERROR) |=>
      (phase == jspt_pkg::PH_FAILED))
    else $error("parser not failed after error");

  // Within one text the pair count never goes down.
  assert property (@(posedge clk) disable iff (rst)
    (proc && !s1.first) |=> (pair_count >= $past(pair_count)))
    else $error("pair count decreased within a text");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import jspt_pkg::*;

  // Cycles with no handshake on either channel before the run is called hung.
  localparam int QUIET_LIMIT = 2000;
  // Length of the long receiver hold-off that fills the block.
  localparam int HOLD_CYCLES = 400;
  // Cycles waited after the last expected word.
  localparam int DRAIN_CYCLES = 8;
  // Mismatch lines printed before further ones are only counted.
  localparam int PRINT_CAP = 30;

  // Tokenizer predictor and store of expected result words.
  class pair_scoreboard #(int COUNT_W = 8);
    phase_t        phase;
    logic [COUNT_W-1:0] pairs;
    result_t       expected_q[$];
    int            errors;
    int            words_in;
    int            words_out;
    int            kind_seen[8];
    int            top_pair;

    function new();
      phase = PH_OPEN;
      pairs = '0;
      errors = 0;
      words_in = 0;
      words_out = 0;
      top_pair = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function bit blank_byte(logic [7:0] c);
      return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // The shown pair index saturates at 255 even if the counter is wider.
    function void expect_word(kind_t k, logic [7:0] d, err_t e);
      result_t r;
      r.kind = k;
      r.data_byte = d;
      r.pair_number = (pairs > 255) ? 8'hFF : 8'(pairs);
      r.error_code = e;
      if (int'(r.pair_number) > top_pair) top_pair = int'(r.pair_number);
      expected_q.push_back(r);
    endfunction

    function void fail_with(err_t e);
      phase = PH_FAILED;
      expect_word(KIND_ERROR, 8'h00, e);
    endfunction

    // Steps the parser by one accepted word. Returns 0 when the word fell
    // after an end or an error and was ignored.
    function bit note_word(item_t w);
      logic [7:0] c;
      bit live;
      c = w.text_byte;
      words_in++;
      if (w.first) begin
        phase = PH_OPEN;
        pairs = '0;
      end
      live = !((phase == PH_FINISHED) || (phase == PH_FAILED));
      case (phase)
        PH_OPEN: begin
          if (!blank_byte(c)) begin
            if ((c == CH_CLOSE_BRACE) || (c == CH_NUL)) begin
              phase = PH_FINISHED;
              expect_word(KIND_EMPTY_END, 8'h00, ERR_NONE);
            end else if (c == CH_OPEN_BRACE) begin
              phase = PH_KEY_QUOTE;
            end else begin
              fail_with(ERR_NO_BRACE);
            end
          end
        end
        PH_KEY_QUOTE: begin
          if (!blank_byte(c)) begin
            if (c == CH_QUOTE) phase = PH_KEY_BODY;
            else fail_with(ERR_NO_KEY_QUOTE);
          end
        end
        PH_KEY_BODY: begin
          if (c == CH_QUOTE) begin
            phase = PH_COLON;
            expect_word(KIND_KEY_END, 8'h00, ERR_NONE);
          end else if (c == CH_NUL) begin
            fail_with(ERR_UNTERMINATED);
          end else begin
            expect_word(KIND_KEY_BYTE, c, ERR_NONE);
          end
        end
        PH_COLON: begin
          if (!blank_byte(c)) begin
            if (c == CH_COLON) phase = PH_VALUE_QUOTE;
            else fail_with(ERR_NO_COLON);
          end
        end
        PH_VALUE_QUOTE: begin
          if (!blank_byte(c)) begin
            if (c == CH_QUOTE) phase = PH_VALUE_BODY;
            else fail_with(ERR_NO_VAL_QUOTE);
          end
        end
        PH_VALUE_BODY: begin
          if (c == CH_QUOTE) begin
            phase = PH_AFTER_VALUE;
            expect_word(KIND_VALUE_END, 8'h00, ERR_NONE);
          end else if (c == CH_NUL) begin
            fail_with(ERR_UNTERMINATED);
          end else begin
            expect_word(KIND_VALUE_BYTE, c, ERR_NONE);
          end
        end
        PH_AFTER_VALUE: begin
          if (!blank_byte(c)) begin
            if (c == CH_COMMA) begin
              if (pairs != {COUNT_W{1'b1}}) pairs++;
              phase = PH_KEY_QUOTE;
            end else if ((c == CH_CLOSE_BRACE) || (c == CH_NUL)) begin
              phase = PH_FINISHED;
              expect_word(KIND_OBJ_END, 8'h00, ERR_NONE);
            end else begin
              fail_with(ERR_TRAILING);
            end
          end
        end
        default: ;
      endcase
      return live;
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compares one accepted result word with the oldest expected word.
    task check_result(result_t got);
      result_t want;
      words_out++;
      if (expected_q.size() == 0) begin
        report($sformatf("result word %0d with nothing expected (kind %0d data %02h)",
                         words_out, got.kind, got.data_byte));
        return;
      end
      want = expected_q.pop_front();
      kind_seen[int'(want.kind)]++;
      if (got.kind !== want.kind)
        report($sformatf("word %0d kind %0d, expected %0d", words_out, got.kind, want.kind));
      if (got.data_byte !== want.data_byte)
        report($sformatf("word %0d data %02h, expected %02h", words_out, got.data_byte,
                         want.data_byte));
      if (got.pair_number !== want.pair_number)
        report($sformatf("word %0d pair %0d, expected %0d", words_out, got.pair_number,
                         want.pair_number));
      if (got.error_code !== want.error_code)
        report($sformatf("word %0d error code %0d, expected %0d", words_out, got.error_code,
                         want.error_code));
    endtask
  endclass

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  pair_scoreboard #(PAIR_COUNT_WIDTH_DEFAULT) sb;

  item_t text_q[$];
  int    live_words;
  int    idle_pct;
  int    stall_pct;
  logic  start_hold;
  logic  hold_off;
  int    send_mix[4] = '{0, 72, 0, 37};
  int    stall_mix[4] = '{0, 0, 72, 37};

  json_string_pair_tokenizer_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Text building helpers; a text is collected in text_q and then sent.
  function automatic void add_word(logic [7:0] b, bit f = 1'b0);
    item_t w;
    w.first = f;
    w.text_byte = b;
    text_q.push_back(w);
  endfunction

  function automatic void add_blanks();
    int n;
    int pick;
    if ($urandom_range(3) == 0) begin
      n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(5);
        add_word((pick == 5) ? CH_SPACE : 8'(9 + pick));
      end
    end
  endfunction

  // A quoted string whose body holds any byte except the quote and NUL.
  function automatic void add_string(int maxlen);
    int len;
    logic [7:0] b;
    len = $urandom_range(0, maxlen);
    add_word(CH_QUOTE);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(1, 255));
      if (b == CH_QUOTE) b = CH_SPACE;
      add_word(b);
    end
    add_word(CH_QUOTE);
  endfunction

  function automatic void mark_start();
    text_q[0].first = 1'b1;
  endfunction

  // A whole object, optionally spoiled by one wrong byte, a NUL or a cut.
  function automatic void build_object(int npairs, int maxlen, bit spoil);
    int pos;
    add_blanks();
    add_word(CH_OPEN_BRACE);
    for (int p = 0; p < npairs; p++) begin
      if (p != 0) add_word(CH_COMMA);
      add_blanks();
      add_string(maxlen);
      add_blanks();
      add_word(CH_COLON);
      add_blanks();
      add_string(maxlen);
      add_blanks();
    end
    add_word(($urandom_range(1) == 1) ? CH_CLOSE_BRACE : CH_NUL);
    mark_start();
    if (spoil) begin
      pos = $urandom_range(0, text_q.size() - 1);
      case ($urandom_range(2))
        0: text_q[pos].text_byte = CH_NUL;
        1: text_q[pos].text_byte = 8'($urandom_range(255));
        default: begin
          while (text_q.size() > pos + 1) void'(text_q.pop_back());
        end
      endcase
    end
    // One stray byte may follow; the block ignores it only after an end or an error.
    if ($urandom_range(4) == 0) add_word(8'($urandom_range(255)));
  endfunction

  // A tight object of empty keys and values with no blanks, closed by a brace.
  function automatic void build_flat_object(int npairs);
    add_word(CH_OPEN_BRACE);
    for (int p = 0; p < npairs; p++) begin
      if (p != 0) add_word(CH_COMMA);
      add_word(CH_QUOTE); add_word(CH_QUOTE); add_word(CH_COLON);
      add_word(CH_QUOTE); add_word(CH_QUOTE);
    end
    add_word(CH_CLOSE_BRACE);
    mark_start();
  endfunction

  // Short runs of arbitrary words, leaning on the grammar characters.
  function automatic void add_noise();
    int n;
    logic [7:0] b;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0: b = CH_OPEN_BRACE;
        1: b = CH_CLOSE_BRACE;
        2: b = CH_QUOTE;
        3: b = CH_COLON;
        4: b = CH_COMMA;
        5: b = CH_NUL;
        default: b = 8'($urandom_range(255));
      endcase
      add_word(b, ($urandom_range(5) == 0));
    end
  endfunction

  // Offers each collected word with random idle gaps and waits for it to be taken.
  task automatic send_text();
    item_t w;
    while (text_q.size() != 0) begin
      w = text_q.pop_front();
      while ($urandom_range(99) < idle_pct) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
      item_valid <= 1'b1;
      item <= w;
      do @(posedge clk); while (item_ready !== 1'b1);
      if (sb.note_word(w)) live_words++;
    end
  endtask

  // Receiver: checks taken words and picks the next ready value.
  always @(posedge clk) begin
    if ((rst === 1'b0) && (result_valid === 1'b1) && (result_ready === 1'b1))
      sb.check_result(result);
    if (hold_off) result_ready <= 1'b0;
    else result_ready <= ($urandom_range(99) >= stall_pct);
  end

  // One long hold-off of the receiver while the sender keeps offering.
  initial begin : receiver_hold
    hold_off <= 1'b0;
    do @(posedge clk); while (start_hold !== 1'b1);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog on cycles without any handshake.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (((item_valid === 1'b1) && (item_ready === 1'b1)) ||
          ((result_valid === 1'b1) && (result_ready === 1'b1)))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no word moved for %0d cycles, %0d still expected", quiet,
             sb.pending());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int goal;
    int roll;
    sb = new();
    live_words = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    start_hold <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Object straight out of reset with no start flag: extreme string bytes,
    // a blank, a second pair with empty strings, closed by NUL.
    add_word(CH_OPEN_BRACE); add_word(CH_QUOTE); add_word(8'hFF); add_word(CH_QUOTE);
    add_word(CH_COLON); add_word(CH_SPACE); add_word(CH_QUOTE); add_word(8'h01);
    add_word(CH_QUOTE); add_word(CH_COMMA); add_word(CH_QUOTE); add_word(CH_QUOTE);
    add_word(CH_COLON); add_word(CH_QUOTE); add_word(CH_QUOTE); add_word(CH_NUL);
    // Empty texts by closing brace and by NUL after a blank; a byte after the end.
    add_word(CH_CLOSE_BRACE, 1'b1);
    add_word(CH_CR, 1'b1); add_word(CH_NUL); add_word(8'h78);
    // Brace right after open is rejected, then silence until the next start.
    add_word(CH_OPEN_BRACE, 1'b1); add_word(CH_CLOSE_BRACE); add_word(CH_CLOSE_BRACE);
    // Missing open brace, and NUL inside a key.
    add_word(8'h61, 1'b1);
    add_word(CH_OPEN_BRACE, 1'b1); add_word(CH_QUOTE); add_word(CH_NUL);
    send_text();

    // Strings while the receiver holds off, so the block backs up.
    start_hold <= 1'b1;
    build_object(4, 12, 1'b0);
    send_text();

    // Enough pairs in one object that the commas run past the count maximum.
    build_flat_object(257);
    send_text();

    // Random texts under each idle mix; mostly whole objects.
    goal = live_words;
    for (int m = 0; m < 4; m++) begin
      idle_pct = send_mix[m];
      stall_pct = stall_mix[m];
      goal += 50;
      while (live_words < goal) begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          build_object($urandom_range(1, 4), ($urandom_range(7) == 0) ? 20 : 5,
                       ($urandom_range(3) == 0));
        end else if (roll < 82) begin
          add_blanks();
          add_word(($urandom_range(1) == 1) ? CH_CLOSE_BRACE : CH_NUL);
          mark_start();
        end else begin
          add_noise();
        end
        send_text();
      end
    end
    item_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d text words taken (%0d parsed), %0d result words checked.",
             sb.words_in, live_words, sb.words_out);
    $display("Summary: %0d string bytes, %0d string ends, %0d text ends, %0d errors.",
             sb.kind_seen[KIND_KEY_BYTE] + sb.kind_seen[KIND_VALUE_BYTE],
             sb.kind_seen[KIND_KEY_END] + sb.kind_seen[KIND_VALUE_END],
             sb.kind_seen[KIND_OBJ_END] + sb.kind_seen[KIND_EMPTY_END],
             sb.kind_seen[KIND_ERROR]);
    $display("Summary: highest pair number seen %0d.", sb.top_pair);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
